@@ src/kpc_pkg.sv @@
package kpc_pkg;

	typedef enum logic [1:0] {
		CMD_CLASSIFY = 2'd0,
		CMD_END_PASS = 2'd1,
		CMD_LOAD     = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	localparam logic [1:0] REG_BANDS = 2'd0;
	localparam logic [1:0] REG_MAXP  = 2'd1;
	localparam logic [1:0] REG_TOL   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLS_RD,
		ST_CLS_WR,
		ST_EOP_RD,
		ST_EOP_DIV,
		ST_EOP_NEXT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [2:0] label;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       converged;
		logic       finished;
		logic [7:0] pass_number;
	} result_t;

	function automatic logic [23:0] palette(input logic [2:0] c);
		case (c)
			3'd0: palette = {8'd205, 8'd197, 8'd191};
			3'd1: palette = {8'd238, 8'd118, 8'd0};
			3'd2: palette = {8'd50, 8'd205, 8'd50};
			3'd3: palette = {8'd135, 8'd206, 8'd250};
			3'd4: palette = {8'd168, 8'd30, 8'd199};
			default: palette = 24'd0;
		endcase
	endfunction

endpackage

@@ src/kpc_divider.sv @@
module kpc_divider import kpc_pkg::*; #(
	parameter int NW = 28,
	parameter int DW = 21
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] q_q;
	logic [DW:0]   r_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   r_sh;

	assign r_sh = {r_q[DW-1:0], q_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			r_q   <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (r_sh >= {1'b0, den_q}) begin
				r_q <= r_sh - {1'b0, den_q};
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
endmodule

@@ src/kmeans_pixel_clustering.sv @@
// K-means pixel classifier, five classes over up to four 8-bit bands.
// s_axis carries commands: classify a pixel, end a pass, or load a center.
// m_axis returns one result per command: label and display colour on
// classify, converged/finished on end of pass, pass count always.
// Configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
// Centers, band sums and class counts live in one synchronous memory row
// per class; a read arrives the cycle after its address. Classify reads all
// rows, keeping the nearest, then writes it back. End of pass walks every
// class and band in use through a radix-2 divider; an empty class skips the
// divider. Load writes the new center while its result is in the output
// state. One command is in flight at a time; the result sits in an output
// register and holds while m_axis_tready is low, and s_axis stays not ready
// until it is taken.
// Reset clears valid bits for all rows, so every row reads as zero until
// written; no clearing pass is needed. Configuration resets to 3/25/1.
module kmeans_pixel_clustering import kpc_pkg::*; #(
	parameter int CLUSTERS = 5,
	parameter int BANDS = 4,
	parameter int PIXEL_COUNT_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// command[1:0], band_value_0..3 [33:2], center_index [36:34], zero pad
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// label[2:0], red, green, blue, converged[27], finished[28],
	// pass_number[36:29], zero pad
	output logic [39:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	localparam int SW = PIXEL_COUNT_BITS + 8;
	localparam int NW = PIXEL_COUNT_BITS + 1;
	localparam int CIW = $clog2(CLUSTERS);
	localparam int BIW = (BANDS > 1) ? $clog2(BANDS) : 1;
	localparam int RW = BANDS * 8 + BANDS * SW + NW;
	localparam logic [SW-1:0] SUM_MAX = '1;
	localparam logic [NW-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic [BANDS-1:0][7:0]    ctr;
		logic [BANDS-1:0][SW-1:0] sum;
		logic [NW-1:0]            cnt;
	} row_t;

	logic [RW-1:0]       mem [CLUSTERS];
	logic [CLUSTERS-1:0] vld_q;
	row_t rd_row, rd_s1, wr_row;
	logic [CIW-1:0] rd_addr, wr_addr;
	logic wr_en, rd_vld_s1;

	logic [2:0] bands_q;
	logic [7:0] maxp_q, tol_q, passes_q;
	state_t st_q, st_d;
	cmd_t cmd_q;
	logic [BANDS-1:0][7:0] px_q;
	logic [CIW-1:0] cidx_q, best_q;
	logic [2:0] cidx_raw_q;
	logic [CIW:0] scan_q;
	logic [17:0] best_d_q;
	logic [BIW-1:0] band_q;
	logic moved_q;
	row_t cur_q;
	result_t res_q;
	logic [BIW:0] nb;
	logic div_start, div_done;
	logic [SW-1:0] quot;

	always_comb begin
		if (bands_q == 3'd0) nb = (BIW+1)'(1);
		else if ({1'b0, bands_q} > 4'(BANDS)) nb = (BIW+1)'(BANDS);
		else nb = (BIW+1)'(bands_q);
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_row;
		rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) vld_q[wr_addr] <= 1'b1;
			rd_vld_s1 <= vld_q[rd_addr];
		end
	end

	assign rd_row = rd_vld_s1 ? rd_s1 : '0;

	// distance of the row that arrived this cycle
	logic [17:0] dsq;
	always_comb begin
		logic [8:0] df;
		dsq = '0;
		for (int b = 0; b < BANDS; b++) begin
			df = (rd_row.ctr[b] >= px_q[b]) ? {1'b0, rd_row.ctr[b] - px_q[b]}
			                               : {1'b0, px_q[b] - rd_row.ctr[b]};
			if ((BIW+1)'(b) < nb) dsq = dsq + 18'(df[7:0] * df[7:0]);
		end
	end

	// read address: scan index during classify, next class during end of
	// pass, class 0 or the load target while idle, load target during output
	always_comb begin
		rd_addr = scan_q[CIW-1:0];
		if (st_q == ST_IDLE)
			rd_addr = (cmd_t'(s_axis_tdata[1:0]) == CMD_LOAD) ? s_axis_tdata[34 +: CIW] : '0;
		if (st_q == ST_EOP_NEXT) rd_addr = CIW'(scan_q + 1'b1);
		if (st_q == ST_OUT) rd_addr = cidx_q;
	end

	logic [7:0] mean8, dlt;
	assign mean8 = (quot > SW'(255)) ? 8'd255 : quot[7:0];
	assign dlt = (mean8 >= cur_q.ctr[band_q]) ? mean8 - cur_q.ctr[band_q]
	                                          : cur_q.ctr[band_q] - mean8;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (s_axis_tvalid) begin
				case (cmd_t'(s_axis_tdata[1:0]))
					CMD_CLASSIFY: st_d = ST_CLS_RD;
					CMD_END_PASS: st_d = ST_EOP_RD;
					default:      st_d = ST_OUT;
				endcase
			end
			ST_CLS_RD: if (scan_q == (CIW+1)'(CLUSTERS)) st_d = ST_CLS_WR;
			ST_CLS_WR: st_d = ST_OUT;
			ST_EOP_RD: st_d = ST_EOP_DIV;
			ST_EOP_DIV: if (cur_q.cnt == '0 || (div_done && 
				(BIW+1)'(band_q) == nb - 1'b1)) st_d = ST_EOP_NEXT;
			ST_EOP_NEXT: st_d = (scan_q == (CIW+1)'(CLUSTERS - 1)) ? ST_OUT : ST_EOP_RD;
			ST_OUT: if (m_axis_tready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (st_q == ST_IDLE);
		m_axis_tvalid = (st_q == ST_OUT);
		wr_en = 1'b0;
		wr_addr = cidx_q;
		wr_row = cur_q;
		case (st_q)
			ST_EOP_RD: ;
			ST_CLS_WR: begin
				wr_en = 1'b1;
				wr_addr = best_q;
				wr_row = cur_q;
				for (int b = 0; b < BANDS; b++)
					if ((BIW+1)'(b) < nb) begin
						if ({1'b0, cur_q.sum[b]} + (SW+1)'(px_q[b]) > (SW+1)'(SUM_MAX))
							wr_row.sum[b] = SUM_MAX;
						else wr_row.sum[b] = cur_q.sum[b] + SW'(px_q[b]);
					end
				if (cur_q.cnt != CNT_MAX) wr_row.cnt = cur_q.cnt + 1'b1;
			end
			ST_EOP_NEXT: begin
				wr_en = 1'b1;
				wr_addr = scan_q[CIW-1:0];
				wr_row.sum = '0;
				wr_row.cnt = '0;
			end
			ST_OUT: if (cmd_q == CMD_LOAD && cidx_raw_q < 3'(CLUSTERS)) begin
				// load writes in every output cycle; rewrites are harmless
				wr_en = 1'b1;
				wr_addr = cidx_q;
				wr_row = rd_row;
				wr_row.ctr = px_q;
			end
			default: ;
		endcase
	end

	logic div_go_q;
	assign div_start = div_go_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			bands_q <= 3'd3;
			maxp_q <= 8'd25;
			tol_q <= 8'd1;
			passes_q <= '0;
			div_go_q <= 1'b0;
		end else begin
			st_q <= st_d;
			div_go_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_BANDS: bands_q <= cfg_data[2:0];
					REG_MAXP:  maxp_q <= cfg_data;
					REG_TOL:   tol_q <= cfg_data;
					default: ;
				endcase
			end
			// empty classes never start the divider
			if (st_q == ST_EOP_RD && rd_row.cnt != '0) div_go_q <= 1'b1;
			if (st_q == ST_EOP_DIV && div_done && (BIW+1)'(band_q) != nb - 1'b1)
				div_go_q <= 1'b1;
			if (st_q == ST_EOP_NEXT && st_d == ST_OUT && passes_q != 8'd255)
				passes_q <= passes_q + 1'b1;
		end
	end

	// the eop row read issued in EOP_NEXT/IDLE arrives in EOP_RD; capture it
	logic [SW-1:0] div_num;
	assign div_num = cur_q.sum[band_q];

	kpc_divider #(.NW(SW), .DW(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(cur_q.cnt), .done(div_done), .quot(quot)
	);

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				cmd_q <= cmd_t'(s_axis_tdata[1:0]);
				for (int b = 0; b < BANDS; b++) px_q[b] <= s_axis_tdata[2+8*b +: 8];
				cidx_raw_q <= s_axis_tdata[36:34];
				cidx_q <= s_axis_tdata[34 +: CIW];
				scan_q <= '0;
				moved_q <= 1'b0;
				res_q <= '0;
			end
			ST_CLS_RD: begin
				if (scan_q != (CIW+1)'(CLUSTERS)) scan_q <= scan_q + 1'b1;
				// keep the nearest row so it can be written back directly
				if (scan_q == (CIW+1)'(1) || (scan_q != '0 && dsq < best_d_q)) begin
					best_d_q <= dsq;
					best_q <= CIW'(scan_q - 1'b1);
					cur_q <= rd_row;
				end
			end
			ST_CLS_WR: begin
				res_q.label <= 3'(best_q);
				{res_q.red, res_q.green, res_q.blue} <= palette(3'(best_q));
			end
			ST_EOP_RD: begin
				cur_q <= rd_row;
				band_q <= '0;
			end
			ST_EOP_DIV: if (div_done && cur_q.cnt != '0) begin
				if (dlt > tol_q) moved_q <= 1'b1;
				cur_q.ctr[band_q] <= mean8;
				band_q <= band_q + 1'b1;
			end
			ST_EOP_NEXT: begin
				scan_q <= scan_q + 1'b1;
				if (st_d == ST_OUT) begin
					res_q.converged <= !moved_q;
					res_q.finished <= !moved_q ||
						((passes_q != 8'd255 ? passes_q + 1'b1 : passes_q) >= maxp_q);
				end
			end
			default: ;
		endcase
		if (st_q == ST_IDLE) cur_q <= '0;
	end

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[2:0] = res_q.label;
		m_axis_tdata[10:3] = res_q.red;
		m_axis_tdata[18:11] = res_q.green;
		m_axis_tdata[26:19] = res_q.blue;
		m_axis_tdata[27] = res_q.converged;
		m_axis_tdata[28] = res_q.finished;
		m_axis_tdata[36:29] = passes_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("accept while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_CLS_WR |-> best_q < CIW'(CLUSTERS))
		else $error("label out of range");
endmodule

@@ sim/kmeans_pixel_clustering_tb.sv @@
module kmeans_pixel_clustering_tb import kpc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCLS = 5;
	localparam int NBND = 4;
	localparam longint SUM_SAT = (64'd1 << 28) - 1;
	localparam int CNT_SAT = (1 << 21) - 1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// command[1:0], band_value_0..3 [33:2], center_index [36:34], zero pad
	logic [39:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// label[2:0], red, green, blue, converged[27], finished[28],
	// pass_number[36:29], zero pad
	logic [39:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	kmeans_pixel_clustering dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("timeout at %0t", $realtime);
		$display("kmeans_pixel_clustering test failed");
		$finish;
	end

	// shadow copy of the classifier state
	logic [7:0] center_mem [NCLS][NBND];
	longint     sum_mem [NCLS][NBND];
	int         count_mem [NCLS];
	logic [7:0] passes;
	logic [2:0] bands_reg = 3'd3;
	logic [7:0] maxp_reg = 8'd25;
	logic [7:0] tol_reg = 8'd1;

	result_t expected_q [$];
	int errors = 0;
	int n_items = 0, n_cls = 0, n_eop = 0, n_done = 0;
	bit quiet = 1'b0;

	function automatic logic [23:0] colour_of(int c);
		case (c)
			0: return {8'd205, 8'd197, 8'd191};
			1: return {8'd238, 8'd118, 8'd0};
			2: return {8'd50, 8'd205, 8'd50};
			3: return {8'd135, 8'd206, 8'd250};
			default: return {8'd168, 8'd30, 8'd199};
		endcase
	endfunction

	task automatic kmeans_step(input cmd_t op, input logic [31:0] px, input logic [2:0] idx,
			output result_t r);
		int nb, best, d, bd, df, mean, delta;
		logic [23:0] col;
		bit moved;
		nb = (bands_reg < 1) ? 1 : (bands_reg > NBND) ? NBND : bands_reg;
		r = '0;
		case (op)
			CMD_CLASSIFY: begin
				best = 0;
				bd = 0;
				for (int c = 0; c < NCLS; c++) begin
					d = 0;
					for (int b = 0; b < nb; b++) begin
						df = int'(center_mem[c][b]) - int'(px[8*b +: 8]);
						d += df * df;
					end
					if (c == 0 || d < bd) begin
						bd = d;
						best = c;
					end
				end
				for (int b = 0; b < nb; b++) begin
					sum_mem[best][b] += px[8*b +: 8];
					if (sum_mem[best][b] > SUM_SAT)
						sum_mem[best][b] = SUM_SAT;
				end
				if (count_mem[best] < CNT_SAT)
					count_mem[best]++;
				col = colour_of(best);
				r.label = best[2:0];
				{r.red, r.green, r.blue} = col;
			end
			CMD_END_PASS: begin
				moved = 1'b0;
				for (int c = 0; c < NCLS; c++) begin
					if (count_mem[c] != 0) begin
						for (int b = 0; b < nb; b++) begin
							mean = int'(sum_mem[c][b] / count_mem[c]);
							if (mean > 255)
								mean = 255;
							delta = mean - int'(center_mem[c][b]);
							if (delta < 0)
								delta = -delta;
							if (delta > tol_reg)
								moved = 1'b1;
							center_mem[c][b] = mean[7:0];
						end
					end
					count_mem[c] = 0;
					for (int b = 0; b < NBND; b++)
						sum_mem[c][b] = 0;
				end
				if (passes != 8'd255)
					passes++;
				r.converged = !moved;
				r.finished = !moved || passes >= maxp_reg;
			end
			CMD_LOAD: begin
				if (idx < NCLS)
					for (int b = 0; b < NBND; b++)
						center_mem[idx][b] = px[8*b +: 8];
			end
			default: ;
		endcase
		r.pass_number = passes;
	endtask

	// result side: random stall bursts, none once quiet
	int stall_left = 0;
	always @(posedge clk) begin
		if (quiet) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(5) == 0) begin
			stall_left <= $urandom_range(2);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v,
				act_v);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction, actual %h", $realtime, m_axis_tdata);
			end else begin
				want = expected_q.pop_front();
				check_field("label", want.label, m_axis_tdata[2:0]);
				check_field("red", want.red, m_axis_tdata[10:3]);
				check_field("green", want.green, m_axis_tdata[18:11]);
				check_field("blue", want.blue, m_axis_tdata[26:19]);
				check_field("converged", want.converged, m_axis_tdata[27]);
				check_field("finished", want.finished, m_axis_tdata[28]);
				check_field("pass_number", want.pass_number, m_axis_tdata[36:29]);
			end
		end
	end

	task automatic send_cmd(input cmd_t op, input logic [31:0] px, input logic [2:0] idx,
			input bit typed, input result_t want);
		result_t r;
		s_axis_tdata <= {3'b0, idx, px, op};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		kmeans_step(op, px, idx, r);
		expected_q.push_back(typed ? want : r);
		n_items++;
		if (op == CMD_CLASSIFY) n_cls++;
		if (op == CMD_END_PASS) begin
			n_eop++;
			if (r.finished) n_done++;
		end
		if (!quiet && $urandom_range(4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic send(input cmd_t op, input logic [31:0] px, input logic [2:0] idx);
		send_cmd(op, px, idx, 1'b0, '0);
	endtask

	// registers only change with nothing in flight
	task automatic set_reg(input logic [1:0] ri, input logic [7:0] v);
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ri;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (ri)
			REG_BANDS: bands_reg = v[2:0];
			REG_MAXP:  maxp_reg = v;
			REG_TOL:   tol_reg = v;
			default: ;
		endcase
	endtask

	function automatic logic [7:0] near(logic [7:0] c);
		int v;
		v = int'(c) + int'($urandom_range(48)) - 24;
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
	endfunction

	typedef struct {
		cmd_t        op;
		logic [31:0] px;
		logic [2:0]  idx;
		bit          typed;
		result_t     want;
	} stim_row_t;

	stim_row_t table_q [$];

	function automatic result_t res(int lab, logic [23:0] col, bit cv, bit fn, int pn);
		result_t r;
		r.label = lab[2:0];
		{r.red, r.green, r.blue} = col;
		r.converged = cv;
		r.finished = fn;
		r.pass_number = pn[7:0];
		return r;
	endfunction

	function automatic void row(cmd_t op, logic [31:0] px, logic [2:0] idx, bit typed,
			result_t want);
		stim_row_t s;
		s.op = op;
		s.px = px;
		s.idx = idx;
		s.typed = typed;
		s.want = want;
		table_q.push_back(s);
	endfunction

	logic [31:0] pix;
	int lim;

	initial begin
		for (int c = 0; c < NCLS; c++) begin
			count_mem[c] = 0;
			for (int b = 0; b < NBND; b++) begin
				center_mem[c][b] = '0;
				sum_mem[c][b] = 0;
			end
		end
		passes = '0;

		// all centers zero after reset: class 0 wins, then an unmoved pass
		row(CMD_CLASSIFY, 32'h0, 3'd0, 1, res(0, 24'hCDC5BF, 0, 0, 0));
		row(CMD_END_PASS, 32'h0, 3'd0, 1, res(0, 24'h0, 1, 1, 1));
		// out of range center index and the spare command leave everything alone
		row(CMD_LOAD, 32'hFFFF_FFFF, 3'd7, 1, res(0, 24'h0, 0, 0, 1));
		row(CMD_LOAD, 32'hFFFF_FFFF, 3'd5, 1, res(0, 24'h0, 0, 0, 1));
		row(CMD_NONE, 32'hFFFF_FFFF, 3'd7, 1, res(0, 24'h0, 0, 0, 1));
		row(CMD_LOAD, 32'hFFFF_FFFF, 3'd0, 0, '0);
		row(CMD_LOAD, 32'h000A_0A0A, 3'd1, 0, '0);
		row(CMD_LOAD, 32'hFF1E_1E1E, 3'd2, 0, '0);
		row(CMD_LOAD, 32'h0000_0000, 3'd3, 0, '0);
		row(CMD_LOAD, 32'h8080_8080, 3'd4, 0, '0);
		// pixel halfway between classes 1 and 2: lower index wins the tie
		row(CMD_CLASSIFY, 32'h0014_1414, 3'd0, 1, res(1, 24'hEE7600, 0, 0, 1));
		row(CMD_CLASSIFY, 32'hFFFF_FFFF, 3'd0, 0, '0);
		row(CMD_CLASSIFY, 32'h0000_0000, 3'd0, 0, '0);
		row(CMD_CLASSIFY, 32'h7F7F_7F7F, 3'd0, 0, '0);
		row(CMD_CLASSIFY, 32'h1F1E_1D20, 3'd7, 0, '0);
		row(CMD_CLASSIFY, 32'hFF00_FF00, 3'd0, 0, '0);
		row(CMD_END_PASS, 32'h0, 3'd0, 0, '0);
		row(CMD_CLASSIFY, 32'h0A0B_0C0D, 3'd0, 0, '0);
		row(CMD_END_PASS, 32'hFFFF_FFFF, 3'd7, 0, '0);
		row(CMD_END_PASS, 32'h0, 3'd0, 0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_q[i])
			send_cmd(table_q[i].op, table_q[i].px, table_q[i].idx, table_q[i].typed,
				table_q[i].want);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin set_reg(REG_BANDS, 8'd1); set_reg(REG_MAXP, 8'd255);
					set_reg(REG_TOL, 8'd0); end
				1: begin set_reg(REG_BANDS, 8'd4); set_reg(REG_MAXP, 8'd0);
					set_reg(REG_TOL, 8'd255); end
				2: begin set_reg(REG_BANDS, 8'd0); set_reg(REG_MAXP, 8'd1);
					set_reg(REG_TOL, 8'd3); end
				3: begin set_reg(REG_BANDS, 8'd7); set_reg(REG_MAXP, 8'd2);
					set_reg(REG_TOL, 8'd0); end
				default: begin
					set_reg(REG_BANDS, 8'($urandom_range(7)));
					set_reg(REG_MAXP, 8'($urandom_range(255)));
					set_reg(REG_TOL, 8'($urandom_range(8)));
				end
			endcase
			for (int c = 0; c < NCLS; c++)
				if (ph < 2 || $urandom_range(3) != 0)
					send(CMD_LOAD, $urandom, c[2:0]);
			for (int p = 0; p < 3; p++) begin
				for (int k = 0; k < 47; k++) begin
					case ($urandom_range(19))
						0: send(CMD_NONE, $urandom, 3'($urandom));
						1: send(CMD_LOAD, $urandom, 3'($urandom_range(5, 7)));
						2, 3: send(CMD_CLASSIFY, $urandom, 3'($urandom));
						default: begin
							lim = $urandom_range(NCLS - 1);
							for (int b = 0; b < NBND; b++)
								pix[8*b +: 8] = near(center_mem[lim][b]);
							send(CMD_CLASSIFY, pix, 3'($urandom));
						end
					endcase
				end
				send(CMD_END_PASS, $urandom, 3'($urandom));
			end
		end

		// no idling from here; run the pass counter into saturation
		quiet = 1'b1;
		while (passes != 8'd255 || n_eop < 270)
			send(CMD_END_PASS, $urandom, 3'($urandom));
		send(CMD_CLASSIFY, $urandom, 3'd0);

		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("%0d commands: %0d pixels classified, %0d passes ended (%0d finished)",
			n_items, n_cls, n_eop, n_done);
		$display("config swept over band counts 0..7, pass limits 0..255, tolerance 0..255");
		if (errors == 0)
			$display("kmeans_pixel_clustering test passed");
		else
			$display("kmeans_pixel_clustering test failed");
		$finish;
	end

endmodule
